>>> rtl/qla_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the q-learning agent
// no dependencies; the files that use it refer to it by scoped names
package qla_pkg;

	localparam int NUM_ACTIONS    = 4;
	localparam int Q_W            = 32;
	localparam int ROW_W          = NUM_ACTIONS * Q_W;
	localparam int STATE_W        = 8;
	localparam int COEF_W         = 16;
	localparam int NUM_STATES_DEF = 256;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [STATE_W-1:0] START_STATE_RST = 8'd0;
	localparam logic [COEF_W-1:0]  LEARN_RATE_RST  = 16'd6554;
	localparam logic [COEF_W-1:0]  DISCOUNT_RST    = 16'd58982;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_START_STATE = 2'd0;
	localparam logic [1:0] REG_LEARN_RATE  = 2'd1;
	localparam logic [1:0] REG_DISCOUNT    = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_NXT,
		ST_MAX,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic rd_cur;
		logic rd_nxt;
		logic cap_cur;
		logic cap_max;
		logic mul1;
		logic mul2;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic mode;
		logic reward_zero;
		logic out_busy;
	} sts_t;

	function automatic logic signed [Q_W-1:0] entry(input logic [ROW_W-1:0] row,
			input logic [1:0] idx);
		return $signed(row[idx*Q_W +: Q_W]);
	endfunction

	// greedy pick, ties keep the lower index
	function automatic logic [1:0] best_idx(input logic [ROW_W-1:0] row);
		logic [1:0] b;
		b = 2'd0;
		for (int i = 1; i < NUM_ACTIONS; i++) begin
			if (entry(row, b) < entry(row, 2'(i))) begin
				b = 2'(i);
			end
		end
		return b;
	endfunction

	function automatic logic signed [Q_W-1:0] sat36(input logic signed [35:0] v);
		logic signed [Q_W-1:0] r;
		if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

>>> rtl/qla_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module qla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/qla_regs.sv
`timescale 1ns / 1ps
// apb register block: start_state, learn_rate, discount
// depends on qla_pkg
module qla_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qla_pkg::ADDR_W-1:0]     paddr,
	input  logic [qla_pkg::DATA_W-1:0]     pwdata,
	output logic [qla_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output logic [qla_pkg::STATE_W-1:0]    start_state,
	output logic                           start_wr,
	output logic [qla_pkg::COEF_W-1:0]     learn_rate,
	output logic [qla_pkg::COEF_W-1:0]     discount
);

	logic [qla_pkg::STATE_W-1:0] start_state_q;
	logic [qla_pkg::COEF_W-1:0]  learn_rate_q;
	logic [qla_pkg::COEF_W-1:0]  discount_q;
	logic                        wr_en;
	logic [1:0]                  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= qla_pkg::START_STATE_RST;
			learn_rate_q  <= qla_pkg::LEARN_RATE_RST;
			discount_q    <= qla_pkg::DISCOUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				qla_pkg::REG_START_STATE: start_state_q <= pwdata[qla_pkg::STATE_W-1:0];
				qla_pkg::REG_LEARN_RATE:  learn_rate_q  <= pwdata[qla_pkg::COEF_W-1:0];
				qla_pkg::REG_DISCOUNT:    discount_q    <= pwdata[qla_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			qla_pkg::REG_START_STATE: prdata = 32'(start_state_q);
			qla_pkg::REG_LEARN_RATE:  prdata = 32'(learn_rate_q);
			qla_pkg::REG_DISCOUNT:    prdata = 32'(discount_q);
			default:                  prdata = '0;
		endcase
	end

	// writing start_state also moves the agent there
	assign start_wr    = wr_en && (reg_idx == qla_pkg::REG_START_STATE);
	assign start_state = pwdata[qla_pkg::STATE_W-1:0];
	assign learn_rate  = learn_rate_q;
	assign discount    = discount_q;

endmodule

>>> rtl/qla_ctrl.sv
`timescale 1ns / 1ps
// controller fsm: table clear sweep, item sequencing, datapath commands
// depends on qla_pkg
module qla_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qla_pkg::sts_t sts,
	output qla_pkg::cmd_t cmd
);

	qla_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qla_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			qla_pkg::ST_CLEAR: begin
				if (sts.clear_done) state_d = qla_pkg::ST_IDLE;
			end
			qla_pkg::ST_IDLE: begin
				if (in_valid) state_d = qla_pkg::ST_RD_NXT;
			end
			qla_pkg::ST_RD_NXT: begin
				// only a learn step with zero reward needs the next row
				if (sts.mode && sts.reward_zero) state_d = qla_pkg::ST_MAX;
				else state_d = qla_pkg::ST_DONE;
			end
			qla_pkg::ST_MAX:  state_d = qla_pkg::ST_MUL1;
			qla_pkg::ST_MUL1: state_d = qla_pkg::ST_MUL2;
			qla_pkg::ST_MUL2: state_d = qla_pkg::ST_DONE;
			qla_pkg::ST_DONE: begin
				if (!sts.out_busy) state_d = qla_pkg::ST_IDLE;
			end
			default: state_d = qla_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			qla_pkg::ST_CLEAR: cmd.clear = 1'b1;
			qla_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.rd_cur = in_valid;
			end
			qla_pkg::ST_RD_NXT: begin
				cmd.cap_cur = 1'b1;
				cmd.rd_nxt  = 1'b1;
			end
			qla_pkg::ST_MAX:  cmd.cap_max = 1'b1;
			qla_pkg::ST_MUL1: cmd.mul1    = 1'b1;
			qla_pkg::ST_MUL2: cmd.mul2    = 1'b1;
			qla_pkg::ST_DONE: cmd.finish  = !sts.out_busy;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qla_pkg::ST_IDLE && in_valid && in_ready) |=>
		(state_q == qla_pkg::ST_RD_NXT))
		else $error("accepted word did not start the row read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy)
		else $error("result loaded while output word still pending");

	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul2 |-> $past(cmd.mul1))
		else $error("second multiply without the first");

	a_max_only_learn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qla_pkg::ST_MAX) |-> (sts.mode && sts.reward_zero))
		else $error("next row max taken outside a zero reward learn step");
`endif

endmodule

>>> rtl/qla_dp.sv
`timescale 1ns / 1ps
// datapath: value table ram, row select, greedy pick, two-multiply update, output register
// depends on qla_pkg and qla_ram
module qla_dp #(
	parameter int NUM_STATES = qla_pkg::NUM_STATES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  qla_pkg::cmd_t                      cmd,
	output qla_pkg::sts_t                      sts,
	input  logic                               in_mode,
	input  logic signed [qla_pkg::Q_W-1:0]     in_reward,
	input  logic [qla_pkg::STATE_W-1:0]        in_next,
	input  logic [qla_pkg::STATE_W-1:0]        start_state,
	input  logic                               start_wr,
	input  logic [qla_pkg::COEF_W-1:0]         learn_rate,
	input  logic [qla_pkg::COEF_W-1:0]         discount,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         out_action,
	output logic [qla_pkg::STATE_W-1:0]        out_state,
	output logic signed [qla_pkg::Q_W-1:0]     out_value
);

	localparam int RIDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

	// state mod NUM_STATES by conditional subtraction, one bit position a step
	function automatic logic [RIDX_W-1:0] row_of(input logic [qla_pkg::STATE_W-1:0] s);
		logic [31:0] r;
		r = 32'(s);
		for (int k = qla_pkg::STATE_W - 1; k >= 0; k--) begin
			if (r >= (32'(NUM_STATES) << k)) begin
				r = r - (32'(NUM_STATES) << k);
			end
		end
		return RIDX_W'(r);
	endfunction

	logic                              mode_q;
	logic signed [qla_pkg::Q_W-1:0]    reward_q;
	logic [qla_pkg::STATE_W-1:0]       next_q;
	logic [qla_pkg::STATE_W-1:0]       occ_q;
	logic [1:0]                        act_q;
	logic [qla_pkg::ROW_W-1:0]         cur_row_q;
	logic signed [qla_pkg::Q_W-1:0]    nmax_q;
	logic signed [48:0]                prod1_q;
	logic signed [50:0]                prod2_q;
	logic [RIDX_W-1:0]                 clr_cnt_q;
	logic                              out_valid_q;
	logic [1:0]                        out_act_q;
	logic [qla_pkg::STATE_W-1:0]       out_state_q;
	logic signed [qla_pkg::Q_W-1:0]    out_value_q;

	logic [qla_pkg::ROW_W-1:0]         ram_rdata;
	logic [qla_pkg::ROW_W-1:0]         ram_wdata;
	logic [qla_pkg::ROW_W-1:0]         wr_row;
	logic [RIDX_W-1:0]                 ram_raddr;
	logic [RIDX_W-1:0]                 ram_waddr;
	logic                              ram_we;
	logic                              ram_re;

	logic signed [qla_pkg::Q_W-1:0]    q;
	logic signed [32:0]                dm;
	logic signed [33:0]                diff;
	logic signed [34:0]                delta;
	logic signed [qla_pkg::Q_W-1:0]    result;

	assign ram_re    = cmd.rd_cur | cmd.rd_nxt;
	assign ram_raddr = cmd.rd_nxt ? row_of(next_q) : row_of(occ_q);
	assign ram_we    = cmd.clear | (cmd.finish & mode_q);
	assign ram_waddr = cmd.clear ? clr_cnt_q : row_of(occ_q);
	assign ram_wdata = cmd.clear ? '0 : wr_row;

	qla_ram #(
		.WIDTH (qla_pkg::ROW_W),
		.DEPTH (NUM_STATES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// in choose mode act_q already holds the greedy pick, so q is the best value
	assign q     = qla_pkg::entry(cur_row_q, act_q);
	assign dm    = $signed(prod1_q[48:16]);
	assign diff  = 34'(dm) - 34'(q);
	assign delta = $signed(prod2_q[50:16]);

	always_comb begin
		if (!mode_q) begin
			result = q;
		end else if (reward_q != '0) begin
			result = qla_pkg::sat36(36'(q) + 36'(reward_q));
		end else begin
			result = qla_pkg::sat36(36'(q) + 36'(delta));
		end
	end

	always_comb begin
		wr_row = cur_row_q;
		wr_row[act_q*qla_pkg::Q_W +: qla_pkg::Q_W] = result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= qla_pkg::START_STATE_RST;
			act_q       <= 2'd0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (start_wr) begin
				occ_q <= start_state;
			end else if (cmd.finish && mode_q) begin
				occ_q <= next_q;
			end
			if (cmd.cap_cur && !mode_q) act_q <= qla_pkg::best_idx(ram_rdata);
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_cur) begin
			mode_q   <= in_mode;
			reward_q <= in_reward;
			next_q   <= in_next;
		end
		if (cmd.cap_cur) cur_row_q <= ram_rdata;
		if (cmd.cap_max) nmax_q <= qla_pkg::entry(ram_rdata, qla_pkg::best_idx(ram_rdata));
		if (cmd.mul1) prod1_q <= $signed({1'b0, discount}) * nmax_q;
		if (cmd.mul2) prod2_q <= $signed({1'b0, learn_rate}) * diff;
		if (cmd.finish) begin
			out_act_q   <= act_q;
			out_state_q <= mode_q ? next_q : occ_q;
			out_value_q <= result;
		end
	end

	assign sts.clear_done  = (clr_cnt_q == RIDX_W'(NUM_STATES - 1));
	assign sts.mode        = mode_q;
	assign sts.reward_zero = (reward_q == '0);
	assign sts.out_busy    = out_valid_q & ~out_ready;

	assign out_valid  = out_valid_q;
	assign out_action = out_act_q;
	assign out_state  = out_state_q;
	assign out_value  = out_value_q;

endmodule

>>> rtl/tabular_q_learning_agent.sv
`timescale 1ns / 1ps
// top level of the tabular q-learning agent: apb registers, controller, datapath
// depends on qla_pkg, qla_regs, qla_ctrl, qla_dp (which holds qla_ram)
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tuser: mode; tdata: reward, next_state
//  m_*      out  m_tvalid / m_tready    tdata: action, current_state, entry_value
//  apb      in   psel/penable/pready    start_state @0, learn_rate @4, discount @8
//
// after reset the value table is swept to zero, one row a cycle, with s_tready
// low; apb writes are taken during the sweep.
// a choose word or a learn word with nonzero reward needs only the row read between
// accept and the next accept; a learn word with zero reward also needs the next-row
// read, row max, then the discount and learn-rate multiplies in turn.
// the result sits in the output register; the next word is accepted while it waits,
// and its result is held back until m_tready takes the previous one.
module tabular_q_learning_agent #(
	parameter int NUM_STATES = qla_pkg::NUM_STATES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [39:0]                 s_tdata,   // reward[31:0], next_state[39:32]
	input  logic [0:0]                  s_tuser,   // mode[0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [47:0]                 m_tdata,   // action[1:0], current_state[9:2],
	                                               // entry_value[41:10], zero[47:42]
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [qla_pkg::ADDR_W-1:0]  paddr,
	input  logic [qla_pkg::DATA_W-1:0]  pwdata,
	output logic [qla_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	qla_pkg::cmd_t                   cmd;
	qla_pkg::sts_t                   sts;
	logic [qla_pkg::STATE_W-1:0]     start_state;
	logic                            start_wr;
	logic [qla_pkg::COEF_W-1:0]      learn_rate;
	logic [qla_pkg::COEF_W-1:0]      discount;
	logic [1:0]                      out_action;
	logic [qla_pkg::STATE_W-1:0]     out_state;
	logic signed [qla_pkg::Q_W-1:0]  out_value;

	qla_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start_state (start_state),
		.start_wr    (start_wr),
		.learn_rate  (learn_rate),
		.discount    (discount)
	);

	qla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qla_dp #(
		.NUM_STATES (NUM_STATES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_mode     (s_tuser[0]),
		.in_reward   ($signed(s_tdata[31:0])),
		.in_next     (s_tdata[39:32]),
		.start_state (start_state),
		.start_wr    (start_wr),
		.learn_rate  (learn_rate),
		.discount    (discount),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_action  (out_action),
		.out_state   (out_state),
		.out_value   (out_value)
	);

	assign m_tdata = {6'd0, out_value, out_state, out_action};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for tabular_q_learning_agent: directed table, then random episodes
// keeps its own copy of the value table and predicts every result word
// depends on qla_pkg and the rtl of the agent
module tb_top;

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  st;
		logic [31:0] val;
	} agent_word_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] rew;
		logic [7:0]  nxt;
		logic        fixed;
		agent_word_t want;
	} dir_row_t;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYC   = 300;
	localparam int PHASE_LEN  = 265;

	// hand-checked rows carry their result, the rest go through the predictor
	localparam dir_row_t DIR_TBL [17] = '{
		// learn before any choice, then reward saturation both ways
		'{1'b1, 32'h7fff_ffff, 8'h00, 1'b1, '{2'd0, 8'h00, 32'h7fff_ffff}},
		'{1'b1, 32'h7fff_ffff, 8'hff, 1'b1, '{2'd0, 8'hff, 32'h7fff_ffff}},
		'{1'b0, 32'h0000_0000, 8'h00, 1'b1, '{2'd0, 8'hff, 32'h0000_0000}},
		'{1'b1, 32'h8000_0000, 8'h00, 1'b1, '{2'd0, 8'h00, 32'h8000_0000}},
		'{1'b1, 32'h8000_0000, 8'hff, 1'b1, '{2'd0, 8'hff, 32'hffff_ffff}},
		'{1'b1, 32'h8000_0000, 8'hff, 1'b1, '{2'd0, 8'hff, 32'h8000_0000}},
		// tie between actions 1..3 goes to the lowest
		'{1'b0, 32'h0000_0000, 8'h00, 1'b1, '{2'd1, 8'hff, 32'h0000_0000}},
		'{1'b1, 32'h0001_0000, 8'haa, 1'b1, '{2'd1, 8'haa, 32'h0001_0000}},
		'{1'b0, 32'h0000_0000, 8'h00, 1'b1, '{2'd0, 8'haa, 32'h0000_0000}},
		// zero reward takes the discounted learning step
		'{1'b1, 32'h0000_0000, 8'hff, 1'b0, '{2'd0, 8'h00, 32'h0000_0000}},
		'{1'b0, 32'h0000_0000, 8'h00, 1'b1, '{2'd1, 8'hff, 32'h0001_0000}},
		'{1'b1, 32'h0000_0000, 8'h00, 1'b0, '{2'd0, 8'h00, 32'h0000_0000}},
		'{1'b1, 32'hffff_0000, 8'h55, 1'b1, '{2'd1, 8'h55, 32'hffff_0000}},
		'{1'b0, 32'hffff_ffff, 8'hff, 1'b1, '{2'd0, 8'h55, 32'h0000_0000}},
		'{1'b1, 32'h0000_0000, 8'hff, 1'b0, '{2'd0, 8'h00, 32'h0000_0000}},
		'{1'b0, 32'h0000_0000, 8'h00, 1'b0, '{2'd0, 8'h00, 32'h0000_0000}},
		'{1'b1, 32'h0000_0001, 8'h00, 1'b0, '{2'd0, 8'h00, 32'h0000_0000}}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // reward[31:0], next_state[39:32]
	logic [0:0]  s_tuser  = '0;   // mode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // action[1:0], current_state[9:2], entry_value[41:10], zero[47:42]
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [qla_pkg::ADDR_W-1:0] paddr  = '0;
	logic [qla_pkg::DATA_W-1:0] pwdata = '0;
	logic [qla_pkg::DATA_W-1:0] prdata;
	logic        pready;

	// predictor state
	int          q_vals [256][4];
	logic [7:0]  occ_state = qla_pkg::START_STATE_RST;
	logic [1:0]  last_act  = 2'd0;
	logic [15:0] lr_reg    = qla_pkg::LEARN_RATE_RST;
	logic [15:0] disc_reg  = qla_pkg::DISCOUNT_RST;

	agent_word_t pending_words [$];
	int          err_count  = 0;
	int          rx_words   = 0;
	int          idle_count = 0;
	int          burst_left = 0;
	bit          hold_done  = 1'b0;

	always #10 clk = ~clk;

	tabular_q_learning_agent dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < 100) begin
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		end
		err_count++;
	endtask

	function automatic logic [31:0] clip_word(input longint v);
		if (v > longint'(32'sh7fff_ffff)) begin
			return 32'h7fff_ffff;
		end else if (v < -longint'(32'sh7fff_ffff) - 1) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [1:0] greedy_pick(input logic [7:0] r);
		logic [1:0] b;
		b = 2'd0;
		for (int i = 1; i < qla_pkg::NUM_ACTIONS; i++) begin
			if (q_vals[r][i] > q_vals[r][b]) begin
				b = 2'(i);
			end
		end
		return b;
	endfunction

	// one step of the agent; with 256 states the 8-bit index is the row itself
	function automatic agent_word_t agent_step(input logic m, input logic [31:0] rw,
			input logic [7:0] ns);
		agent_word_t w;
		logic [1:0]  a;
		longint      q, mx, dm, dl;
		if (!m) begin
			last_act = greedy_pick(occ_state);
			w.val = q_vals[occ_state][last_act];
		end else begin
			a = last_act;
			q = longint'(q_vals[occ_state][a]);
			if (rw != '0) begin
				w.val = clip_word(q + longint'($signed(rw)));
			end else begin
				mx = longint'(q_vals[ns][greedy_pick(ns)]);
				// arithmetic shifts round toward minus infinity
				dm = (longint'(disc_reg) * mx) >>> 16;
				dl = (longint'(lr_reg) * (dm - q)) >>> 16;
				w.val = clip_word(q + dl);
			end
			q_vals[occ_state][a] = w.val;
			occ_state = ns;
		end
		w.act = last_act;
		w.st  = occ_state;
		return w;
	endfunction

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			qla_pkg::REG_START_STATE: occ_state = val[7:0];
			qla_pkg::REG_LEARN_RATE:  lr_reg    = val[15:0];
			qla_pkg::REG_DISCOUNT:    disc_reg  = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offers one word in bursts with random gaps, then records what should come back
	task automatic send_word(input logic m, input logic [31:0] rw, input logic [7:0] ns,
			input logic fixed, input agent_word_t fixed_word);
		agent_word_t pred;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= {ns, rw};
		do @(posedge clk); while (!s_tready);
		pred = agent_step(m, rw, ns);
		pending_words.push_back(fixed ? fixed_word : pred);
	endtask

	function automatic logic [31:0] pick_reward();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 9) begin
			return 32'h0;
		end else if (sel < 15) begin
			return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
		end else if (sel < 17) begin
			return 32'($urandom_range(0, 32'hffffff)) - 32'h800000;
		end else if (sel == 17) begin
			return $urandom;
		end else if (sel == 18) begin
			return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		end
		return $urandom_range(0, 1) ? 32'($urandom_range(1, 15)) : -32'($urandom_range(1, 15));
	endfunction

	// mostly a small pool of states so values build up, sometimes any state
	function automatic logic [7:0] pick_state();
		logic [2:0] s;
		s = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 9) < 7) begin
			return {s[2] ? 6'h3f : 6'h00, s[1:0]};
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic run_phase(input logic [7:0] st, input logic [15:0] lr,
			input logic [15:0] disc, input int n);
		int k;
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		// upper bits are junk the block must ignore
		apb_write(qla_pkg::REG_START_STATE, {24'($urandom), st});
		apb_write(qla_pkg::REG_LEARN_RATE, {16'($urandom), lr});
		apb_write(qla_pkg::REG_DISCOUNT, {16'($urandom), disc});
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 9) < 8) begin
				// choose, then learn from the move
				send_word(1'b0, $urandom, 8'($urandom), 1'b0, '0);
				send_word(1'b1, pick_reward(), pick_state(), 1'b0, '0);
				k += 2;
			end else begin
				send_word(1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)),
					1'b0, '0);
				k++;
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 17; i++) begin
			send_word(DIR_TBL[i].mode, DIR_TBL[i].rew, DIR_TBL[i].nxt,
				DIR_TBL[i].fixed, DIR_TBL[i].want);
		end
		run_phase(8'hff, 16'hffff, 16'hffff, PHASE_LEN);
		run_phase(8'h00, 16'h0000, 16'h0000, PHASE_LEN);
		run_phase(qla_pkg::START_STATE_RST, qla_pkg::LEARN_RATE_RST,
			qla_pkg::DISCOUNT_RST, PHASE_LEN);
		repeat (3) begin
			run_phase(8'($urandom), 16'($urandom), 16'($urandom), PHASE_LEN);
		end
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// receiver stall pattern, with one long hold-off to back the block up
	initial begin : rx_pattern
		int seg;
		int len;
		@(posedge clk);
		forever begin
			if (!hold_done && rx_words >= 300) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			seg = $urandom_range(0, 3);
			len = (seg == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
			repeat (len) begin
				case (seg)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= 1'b0;
					default: m_tready <= ~m_tready;
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		agent_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rx_words++;
			if (pending_words.size() == 0) begin
				report_mismatch("word with nothing pending", m_tdata[41:10], '0);
			end else begin
				want = pending_words.pop_front();
				if (m_tdata[1:0] !== want.act) begin
					report_mismatch("action", 32'(m_tdata[1:0]), 32'(want.act));
				end
				if (m_tdata[9:2] !== want.st) begin
					report_mismatch("current_state", 32'(m_tdata[9:2]), 32'(want.st));
				end
				if (m_tdata[41:10] !== want.val) begin
					report_mismatch("entry_value", m_tdata[41:10], want.val);
				end
				if (m_tdata[47:42] !== 6'd0) begin
					report_mismatch("pad bits", 32'(m_tdata[47:42]), 32'd0);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
		end
		if (idle_count >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
